/* rtl/zsvd_pkg.sv */
// ----------------------------------------------------------------------------
// zsvd_pkg: shared types, constants and code tables
// Length code tables (base value and extra bit count) and field widths for
// the zstd sequence value decoder.
// ----------------------------------------------------------------------------
package zsvd_pkg;

  localparam int unsigned LL_CODES   = 36;
  localparam int unsigned ML_CODES   = 53;

  localparam int unsigned LL_CODE_W  = 6;
  localparam int unsigned ML_CODE_W  = 6;
  localparam int unsigned OF_CODE_W  = 5;
  localparam int unsigned EXTRA_W    = 16;
  localparam int unsigned OF_EXTRA_W = 31;
  localparam int unsigned LIT_LEN_W  = 17;
  localparam int unsigned MATCH_W    = 18;
  localparam int unsigned OFFSET_W   = 32;
  localparam int unsigned BITS_W     = 5;

  // Repeat offset values loaded at reset and at each new frame
  localparam logic [OFFSET_W-1:0] REP0_INIT = 32'd1;
  localparam logic [OFFSET_W-1:0] REP1_INIT = 32'd4;
  localparam logic [OFFSET_W-1:0] REP2_INIT = 32'd8;

  typedef enum logic {
    FUNC_DECODE    = 1'b0,
    FUNC_NEW_FRAME = 1'b1
  } func_e;

  function automatic logic [LIT_LEN_W-1:0] ll_base(input logic [LL_CODE_W-1:0] code);
    logic [LIT_LEN_W-1:0] b;
    b = '0;
    if (code < LL_CODE_W'(16)) begin
      b = LIT_LEN_W'(code);
    end else begin
      case (code)
        6'd16:   b = 17'd16;
        6'd17:   b = 17'd18;
        6'd18:   b = 17'd20;
        6'd19:   b = 17'd22;
        6'd20:   b = 17'd24;
        6'd21:   b = 17'd28;
        6'd22:   b = 17'd32;
        6'd23:   b = 17'd40;
        6'd24:   b = 17'd48;
        6'd25:   b = 17'd64;
        6'd26:   b = 17'd128;
        6'd27:   b = 17'd256;
        6'd28:   b = 17'd512;
        6'd29:   b = 17'd1024;
        6'd30:   b = 17'd2048;
        6'd31:   b = 17'd4096;
        6'd32:   b = 17'd8192;
        6'd33:   b = 17'd16384;
        6'd34:   b = 17'd32768;
        6'd35:   b = 17'd65536;
        default: b = '0;
      endcase
    end
    return b;
  endfunction

  function automatic logic [BITS_W-1:0] ll_bits(input logic [LL_CODE_W-1:0] code);
    logic [BITS_W-1:0] n;
    case (code)
      6'd16, 6'd17, 6'd18, 6'd19: n = 5'd1;
      6'd20, 6'd21:               n = 5'd2;
      6'd22, 6'd23:               n = 5'd3;
      6'd24:                      n = 5'd4;
      6'd25:                      n = 5'd6;
      6'd26:                      n = 5'd7;
      6'd27:                      n = 5'd8;
      6'd28:                      n = 5'd9;
      6'd29:                      n = 5'd10;
      6'd30:                      n = 5'd11;
      6'd31:                      n = 5'd12;
      6'd32:                      n = 5'd13;
      6'd33:                      n = 5'd14;
      6'd34:                      n = 5'd15;
      6'd35:                      n = 5'd16;
      default:                    n = '0;
    endcase
    return n;
  endfunction

  function automatic logic [LIT_LEN_W-1:0] ml_base(input logic [ML_CODE_W-1:0] code);
    logic [LIT_LEN_W-1:0] b;
    b = '0;
    if (code < ML_CODE_W'(32)) begin
      b = LIT_LEN_W'(code) + 17'd3;
    end else begin
      case (code)
        6'd32:   b = 17'd35;
        6'd33:   b = 17'd37;
        6'd34:   b = 17'd39;
        6'd35:   b = 17'd41;
        6'd36:   b = 17'd43;
        6'd37:   b = 17'd47;
        6'd38:   b = 17'd51;
        6'd39:   b = 17'd59;
        6'd40:   b = 17'd67;
        6'd41:   b = 17'd83;
        6'd42:   b = 17'd99;
        6'd43:   b = 17'd131;
        6'd44:   b = 17'd259;
        6'd45:   b = 17'd515;
        6'd46:   b = 17'd1027;
        6'd47:   b = 17'd2051;
        6'd48:   b = 17'd4099;
        6'd49:   b = 17'd8195;
        6'd50:   b = 17'd16387;
        6'd51:   b = 17'd32771;
        6'd52:   b = 17'd65539;
        default: b = '0;
      endcase
    end
    return b;
  endfunction

  function automatic logic [BITS_W-1:0] ml_bits(input logic [ML_CODE_W-1:0] code);
    logic [BITS_W-1:0] n;
    case (code)
      6'd32, 6'd33, 6'd34, 6'd35: n = 5'd1;
      6'd36, 6'd37:               n = 5'd2;
      6'd38, 6'd39:               n = 5'd3;
      6'd40, 6'd41:               n = 5'd4;
      6'd42:                      n = 5'd5;
      6'd43:                      n = 5'd7;
      6'd44:                      n = 5'd8;
      6'd45:                      n = 5'd9;
      6'd46:                      n = 5'd10;
      6'd47:                      n = 5'd11;
      6'd48:                      n = 5'd12;
      6'd49:                      n = 5'd13;
      6'd50:                      n = 5'd14;
      6'd51:                      n = 5'd15;
      6'd52:                      n = 5'd16;
      default:                    n = '0;
    endcase
    return n;
  endfunction

  // Low mask of n ones over an extra-bits field (n up to 16)
  function automatic logic [EXTRA_W-1:0] extra_mask(input logic [BITS_W-1:0] n);
    logic [EXTRA_W:0] m;
    m = (17'd1 << n) - 17'd1;
    return m[EXTRA_W-1:0];
  endfunction

endpackage

/* rtl/zstd_sequence_value_decode.sv */
// ----------------------------------------------------------------------------
// zstd_sequence_value_decode: zstd sequence values and repeat offsets
// Turns literal-length, match-length and offset codes with their extra-bit
// values into lengths and a resolved match offset, keeping the three-entry
// repeat-offset history.
// ----------------------------------------------------------------------------
// One word in is one sequence (func = decode) or a new-frame marker
// (func = new frame) that reloads the repeat offsets to 1, 4, 8 and yields no
// output word. A word is taken every cycle unless the input stalls behind a
// decode word that has no room in the output register. A decode word passes
// the input register, then one pass of table lookup, add and history update
// into the output register. The history register is read and written in that
// same pass, so back-to-back sequences see each other's updates. A repeat
// offset that resolves to zero still gives a word, with lengths decoded,
// match_offset 0 and bad_repeat set; the history is then left alone.
// ----------------------------------------------------------------------------
module zstd_sequence_value_decode (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic [zsvd_pkg::LL_CODE_W-1:0]   ll_code_i,
  input  logic [zsvd_pkg::EXTRA_W-1:0]     ll_extra_i,
  input  logic [zsvd_pkg::ML_CODE_W-1:0]   ml_code_i,
  input  logic [zsvd_pkg::EXTRA_W-1:0]     ml_extra_i,
  input  logic [zsvd_pkg::OF_CODE_W-1:0]   of_code_i,
  input  logic [zsvd_pkg::OF_EXTRA_W-1:0]  of_extra_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [zsvd_pkg::LIT_LEN_W-1:0]   lit_len_o,
  output logic [zsvd_pkg::MATCH_W-1:0]     copy_len_o,
  output logic [zsvd_pkg::OFFSET_W-1:0]    match_offset_o,
  output logic                             bad_repeat_o
);
  import zsvd_pkg::*;

  // input register
  logic                  s1_valid_q, s1_valid_d;
  func_e                 s1_func_q;
  logic [LL_CODE_W-1:0]  s1_ll_code_q;
  logic [EXTRA_W-1:0]    s1_ll_extra_q;
  logic [ML_CODE_W-1:0]  s1_ml_code_q;
  logic [EXTRA_W-1:0]    s1_ml_extra_q;
  logic [OF_CODE_W-1:0]  s1_of_code_q;
  logic [OF_EXTRA_W-1:0] s1_of_extra_q;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [LIT_LEN_W-1:0]  lit_len_q;
  logic [MATCH_W-1:0]    copy_len_q;
  logic [OFFSET_W-1:0]   offset_q, offset_d;
  logic                  bad_q, bad_d;

  // repeat-offset history, entry 0 is most recent
  logic [OFFSET_W-1:0]   hist0_q, hist1_q, hist2_q;
  logic [OFFSET_W-1:0]   hist0_d, hist1_d, hist2_d;

  logic                  in_accept;
  logic                  out_free;
  logic                  s1_fire;
  logic                  s1_decode;
  logic [LIT_LEN_W-1:0]  lit_len;
  logic [MATCH_W-1:0]    copy_len;
  logic [OFFSET_W-1:0]   of_pow;
  logic [OFFSET_W-1:0]   of_mask;
  logic [OFFSET_W-1:0]   of_new;
  logic                  lit_zero;
  logic [1:0]            rep_sel;
  logic [OFFSET_W-1:0]   rep_cand;

  // handshake: a decode word needs room in the output register,
  // a new-frame word only touches the history
  assign s1_decode  = (s1_func_q == FUNC_DECODE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && (!s1_decode || out_free);
  assign in_stall_o = s1_valid_q && !s1_fire;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_accept || (s1_valid_q && !s1_fire);

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_fire && s1_decode) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q     <= func_e'(func_i);
      s1_ll_code_q  <= ll_code_i;
      s1_ll_extra_q <= ll_extra_i;
      s1_ml_code_q  <= ml_code_i;
      s1_ml_extra_q <= ml_extra_i;
      s1_of_code_q  <= of_code_i;
      s1_of_extra_q <= of_extra_i;
    end
  end

  zsvd_len_dec u_len_dec (
    .ll_code_i  (s1_ll_code_q),
    .ll_extra_i (s1_ll_extra_q),
    .ml_code_i  (s1_ml_code_q),
    .ml_extra_i (s1_ml_extra_q),
    .lit_len_o  (lit_len),
    .copy_len_o (copy_len)
  );

  // new offset: (1 << code) + masked extra - 3; extra stays below the power
  assign of_pow  = OFFSET_W'(1) << s1_of_code_q;
  assign of_mask = of_pow - OFFSET_W'(1);
  assign of_new  = (of_pow | ({1'b0, s1_of_extra_q} & of_mask)) - OFFSET_W'(3);

  // repeat select 1..3, shifted by one when there are no literals
  assign lit_zero = (lit_len == '0);
  assign rep_sel  = 2'd1 + {1'b0, lit_zero} + {1'b0, s1_of_extra_q[0]};
  assign rep_cand = (rep_sel == 2'd3) ? (hist0_q - OFFSET_W'(1)) :
                    (rep_sel == 2'd2) ? hist2_q : hist1_q;

  always_comb begin
    hist0_d  = hist0_q;
    hist1_d  = hist1_q;
    hist2_d  = hist2_q;
    offset_d = '0;
    bad_d    = 1'b0;
    if (!s1_decode) begin
      hist0_d = REP0_INIT;
      hist1_d = REP1_INIT;
      hist2_d = REP2_INIT;
    end else if (s1_of_code_q > OF_CODE_W'(1)) begin
      offset_d = of_new;
      hist0_d  = of_new;
      hist1_d  = hist0_q;
      hist2_d  = hist1_q;
    end else if (s1_of_code_q == '0) begin
      if (lit_zero) begin
        offset_d = hist1_q;
        hist0_d  = hist1_q;
        hist1_d  = hist0_q;
      end else begin
        offset_d = hist0_q;
      end
    end else if (rep_cand == '0) begin
      bad_d = 1'b1;
    end else begin
      offset_d = rep_cand;
      hist0_d  = rep_cand;
      hist1_d  = hist0_q;
      if (rep_sel != 2'd1) begin
        hist2_d = hist1_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist0_q <= REP0_INIT;
      hist1_q <= REP1_INIT;
      hist2_q <= REP2_INIT;
    end else if (s1_fire) begin
      hist0_q <= hist0_d;
      hist1_q <= hist1_d;
      hist2_q <= hist2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_decode) begin
      lit_len_q  <= lit_len;
      copy_len_q <= copy_len;
      offset_q   <= offset_d;
      bad_q      <= bad_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign lit_len_o      = lit_len_q;
  assign copy_len_o     = copy_len_q;
  assign match_offset_o = offset_q;
  assign bad_repeat_o   = bad_q;

  // history never holds a zero offset
  a_hist_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist0_q != '0) && (hist1_q != '0) && (hist2_q != '0))
    else $error("repeat history holds zero");

  // a flagged word carries offset zero
  a_bad_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bad_q) |-> (offset_q == '0))
    else $error("bad repeat with nonzero offset");

  // new frame reloads the history
  a_new_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_decode) |=>
      (hist0_q == REP0_INIT) && (hist1_q == REP1_INIT) && (hist2_q == REP2_INIT))
    else $error("history not reloaded on new frame");

  // input stalls only behind a word that cannot move on
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_decode && out_valid_q && out_stall_i))
    else $error("input stalled without cause");

  // a flagged word leaves history entries 0 and 1 untouched
  a_bad_keeps_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && s1_decode && bad_d) |=> $stable(hist0_q) && $stable(hist1_q))
    else $error("history changed on bad repeat");

endmodule

/* rtl/zsvd_len_dec.sv */
// ----------------------------------------------------------------------------
// zsvd_len_dec: literal and match length decode
// Table base plus masked extra bits; codes beyond a table decode to zero.
// ----------------------------------------------------------------------------
module zsvd_len_dec (
  input  logic [zsvd_pkg::LL_CODE_W-1:0] ll_code_i,
  input  logic [zsvd_pkg::EXTRA_W-1:0]   ll_extra_i,
  input  logic [zsvd_pkg::ML_CODE_W-1:0] ml_code_i,
  input  logic [zsvd_pkg::EXTRA_W-1:0]   ml_extra_i,
  output logic [zsvd_pkg::LIT_LEN_W-1:0] lit_len_o,
  output logic [zsvd_pkg::MATCH_W-1:0]   copy_len_o
);
  import zsvd_pkg::*;

  logic [EXTRA_W-1:0] ll_ext;
  logic [EXTRA_W-1:0] ml_ext;

  assign ll_ext = ll_extra_i & extra_mask(ll_bits(ll_code_i));
  assign ml_ext = ml_extra_i & extra_mask(ml_bits(ml_code_i));

  // wide literal bases are powers of two, so no carry out; copy_len has a spare bit
  assign lit_len_o  = ll_base(ll_code_i) + LIT_LEN_W'(ll_ext);
  assign copy_len_o = MATCH_W'(ml_base(ml_code_i)) + MATCH_W'(ml_ext);

endmodule

/* tb/tb_zstd_sequence_value_decode.sv */
// ----------------------------------------------------------------------------
// tb_zstd_sequence_value_decode: self-checking bench for the sequence decoder
// Drives directed and random sequence words through the valid/stall input,
// predicts lengths, offsets and the repeat-offset history in the bench, and
// checks every output word in order against the prediction.
// ----------------------------------------------------------------------------
module tb_zstd_sequence_value_decode;
  import zsvd_pkg::*;

  // one input word as queued for the driver
  typedef struct {
    func_e                  func;
    logic [LL_CODE_W-1:0]   ll_code;
    logic [EXTRA_W-1:0]     ll_extra;
    logic [ML_CODE_W-1:0]   ml_code;
    logic [EXTRA_W-1:0]     ml_extra;
    logic [OF_CODE_W-1:0]   of_code;
    logic [OF_EXTRA_W-1:0]  of_extra;
    int unsigned            gap;          // idle cycles after this word
    bit                     drain_first;  // hold off until all results are in
  } seq_word_t;

  // one output word
  typedef struct packed {
    logic [LIT_LEN_W-1:0] lit_len;
    logic [MATCH_W-1:0]   copy_len;
    logic [OFFSET_W-1:0]  match_offset;
    logic                 bad_repeat;
  } seq_values_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   func;
  logic [LL_CODE_W-1:0]   ll_code;
  logic [EXTRA_W-1:0]     ll_extra;
  logic [ML_CODE_W-1:0]   ml_code;
  logic [EXTRA_W-1:0]     ml_extra;
  logic [OF_CODE_W-1:0]   of_code;
  logic [OF_EXTRA_W-1:0]  of_extra;
  logic                   out_valid;
  logic                   out_stall;
  logic [LIT_LEN_W-1:0]   lit_len;
  logic [MATCH_W-1:0]     copy_len;
  logic [OFFSET_W-1:0]    match_offset;
  logic                   bad_repeat;

  // bench copy of the length code tables and the repeat-offset history
  int unsigned            lit_base_tab [LL_CODES];
  int unsigned            lit_bits_tab [LL_CODES];
  int unsigned            mat_base_tab [ML_CODES];
  int unsigned            mat_bits_tab [ML_CODES];
  logic [OFFSET_W-1:0]    rep_hist [3];

  seq_word_t              sequence_words [$];  // words not yet presented
  seq_values_t            decoded_backlog [$]; // predicted, not yet seen
  int unsigned            words_total;
  int unsigned            words_taken;
  int unsigned            fault_count;
  int unsigned            calm_words;          // words left in a no-gap stretch
  int unsigned            idle_left;
  int unsigned            ostall_left;
  int unsigned            ocalm_left;
  bit                     word_taken;          // input accepted at last rising edge

  zstd_sequence_value_decode dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (func),
    .ll_code_i      (ll_code),
    .ll_extra_i     (ll_extra),
    .ml_code_i      (ml_code),
    .ml_extra_i     (ml_extra),
    .of_code_i      (of_code),
    .of_extra_i     (of_extra),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .lit_len_o      (lit_len),
    .copy_len_o     (copy_len),
    .match_offset_o (match_offset),
    .bad_repeat_o   (bad_repeat)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predict one word. Returns 1 when the word yields an output word.
  // Updates the bench history exactly as the block is meant to.
  function automatic bit decode_sequence(input seq_word_t w, output seq_values_t r);
    logic [OFFSET_W-1:0] cand;
    longint unsigned     wide;
    int unsigned         sel;
    bit                  shift;
    r = '0;
    if (w.func == FUNC_NEW_FRAME) begin
      rep_hist[0] = REP0_INIT;
      rep_hist[1] = REP1_INIT;
      rep_hist[2] = REP2_INIT;
      return 1'b0;
    end
    // lengths: out-of-range codes give zero
    if (w.ll_code < LL_CODES) begin
      r.lit_len = LIT_LEN_W'(lit_base_tab[w.ll_code] +
                             (w.ll_extra & ((32'd1 << lit_bits_tab[w.ll_code]) - 1)));
    end
    if (w.ml_code < ML_CODES) begin
      r.copy_len = MATCH_W'(mat_base_tab[w.ml_code] +
                            (w.ml_extra & ((32'd1 << mat_bits_tab[w.ml_code]) - 1)));
    end
    if (w.of_code > 1) begin
      // explicit offset, pushed onto the history
      wide = (64'd1 << w.of_code) + (w.of_extra & ((64'd1 << w.of_code) - 1)) - 64'd3;
      r.match_offset = wide[OFFSET_W-1:0];
      rep_hist[2] = rep_hist[1];
      rep_hist[1] = rep_hist[0];
      rep_hist[0] = r.match_offset;
    end else begin
      // repeat offset; selection moves up by one on zero literals
      shift = (r.lit_len == '0);
      if (w.of_code == 0) begin
        if (shift) begin
          r.match_offset = rep_hist[1];
          rep_hist[1] = rep_hist[0];
          rep_hist[0] = r.match_offset;
        end else begin
          r.match_offset = rep_hist[0];
        end
      end else begin
        sel = 1 + shift + w.of_extra[0];
        if (sel == 3) cand = rep_hist[0] - 1;
        else cand = rep_hist[sel];
        if (cand == '0) begin
          r.bad_repeat = 1'b1;   // history untouched
        end else begin
          if (sel != 1) rep_hist[2] = rep_hist[1];
          rep_hist[1] = rep_hist[0];
          rep_hist[0] = cand;
          r.match_offset = cand;
        end
      end
    end
    return 1'b1;
  endfunction

  // Queue one word; the idle gap after it is drawn here, mostly short.
  task automatic push_word(input func_e f, input logic [LL_CODE_W-1:0] llc,
                           input logic [EXTRA_W-1:0] lle, input logic [ML_CODE_W-1:0] mlc,
                           input logic [EXTRA_W-1:0] mle, input logic [OF_CODE_W-1:0] ofc,
                           input logic [OF_EXTRA_W-1:0] ofe, input bit drain);
    seq_word_t   w;
    int unsigned roll;
    w.func = f;
    w.ll_code = llc;
    w.ll_extra = lle;
    w.ml_code = mlc;
    w.ml_extra = mle;
    w.of_code = ofc;
    w.of_extra = ofe;
    w.drain_first = drain;
    roll = $urandom_range(0, 99);
    if (calm_words > 0) begin
      calm_words--;
      w.gap = 0;
    end else if (roll < 2) begin
      calm_words = $urandom_range(30, 150);
      w.gap = 0;
    end else if (roll < 55) begin
      w.gap = 0;
    end else if (roll < 90) begin
      w.gap = $urandom_range(1, 3);
    end else if (roll < 97) begin
      w.gap = $urandom_range(4, 10);
    end else begin
      w.gap = $urandom_range(20, 60);
    end
    sequence_words.insert(sequence_words.size(), w);
  endtask

  // Stimulus, reset and end of run
  initial begin
    int          c;
    int unsigned q;
    logic [LL_CODE_W-1:0]  llc;
    logic [ML_CODE_W-1:0]  mlc;
    logic [OF_CODE_W-1:0]  ofc;
    logic [OF_EXTRA_W-1:0] ofe;
    rst_n = 1'b0;
    in_valid = 1'b0;
    func = 1'b0;
    ll_code = '0;
    ll_extra = '0;
    ml_code = '0;
    ml_extra = '0;
    of_code = '0;
    of_extra = '0;
    out_stall = 1'b0;
    words_taken = 0;
    fault_count = 0;
    calm_words = 0;
    idle_left = 0;
    ostall_left = 0;
    ocalm_left = 0;
    word_taken = 1'b0;
    rep_hist[0] = REP0_INIT;
    rep_hist[1] = REP1_INIT;
    rep_hist[2] = REP2_INIT;

    // code tables: each base is the previous base plus its extra range
    for (c = 0; c < LL_CODES; c++) begin
      lit_bits_tab[c] = (c < 16) ? 0 : (c < 20) ? 1 : (c < 22) ? 2 :
                        (c < 24) ? 3 : (c == 24) ? 4 : c - 19;
      lit_base_tab[c] = (c <= 16) ? c : lit_base_tab[c-1] + (1 << lit_bits_tab[c-1]);
    end
    for (c = 0; c < ML_CODES; c++) begin
      mat_bits_tab[c] = (c < 32) ? 0 : (c < 36) ? 1 : (c < 38) ? 2 : (c < 40) ? 3 :
                        (c < 42) ? 4 : (c == 42) ? 5 : c - 36;
      mat_base_tab[c] = (c <= 32) ? c + 3 : mat_base_tab[c-1] + (1 << mat_bits_tab[c-1]);
    end

    // directed: repeat-offset selections from the reset history, zero
    // resolution, out-of-range codes, field maxima and masked extra bits
    push_word(FUNC_NEW_FRAME, '1, '1, '1, '1, '1, '1, 1'b0);
    push_word(FUNC_DECODE, 0, 0, 0, 0, 1, 1, 1'b0);        // rep0-1 = 0: bad
    push_word(FUNC_DECODE, 0, 0, 0, 0, 1, 0, 1'b0);
    push_word(FUNC_DECODE, 1, 0, 0, 0, 1, 0, 1'b0);
    push_word(FUNC_DECODE, 1, 0, 0, 0, 1, 1, 1'b0);
    push_word(FUNC_DECODE, 0, 0, 0, 0, 1, 1, 1'b0);
    push_word(FUNC_DECODE, 1, 0, 0, 0, 0, 0, 1'b0);
    push_word(FUNC_DECODE, '1, '1, '1, '1, 0, 0, 1'b0);    // codes beyond tables
    push_word(FUNC_DECODE, 35, '1, 52, '1, 31, '1, 1'b0);  // maxima
    push_word(FUNC_DECODE, 35, 0, 52, 0, 31, 0, 1'b0);
    push_word(FUNC_DECODE, 16, '1, 32, '1, 2, '1, 1'b0);   // extras masked
    push_word(FUNC_DECODE, 36, '1, 53, '1, 2, 0, 1'b0);    // offset 1
    push_word(FUNC_DECODE, 0, 0, 0, 0, 1, '1, 1'b0);       // bad again
    push_word(FUNC_DECODE, 15, 16'h1234, 31, 16'h1234, 1, 31'h7FFF_FFFE, 1'b0);
    push_word(FUNC_DECODE, 24, '1, 44, '1, 3, '1, 1'b0);
    push_word(FUNC_NEW_FRAME, 0, 0, 0, 0, 0, 0, 1'b0);
    push_word(FUNC_DECODE, 0, 0, 0, 0, 1, 1, 1'b0);        // bad after reload
    push_word(FUNC_DECODE, 0, 0, 0, 0, 0, 0, 1'b0);
    push_word(FUNC_DECODE, 0, 16'hAAAA, 0, 16'h5555, 2, 31'h5555_5555, 1'b0);
    push_word(FUNC_DECODE, 34, 16'h5555, 51, 16'hAAAA, 30, 31'h2AAA_AAAA, 1'b0);

    // random: short frames of sequences, heavy on repeat offsets and zero
    // literal lengths so the history is exercised; some frame noise
    for (c = 0; c < 1250; c++) begin
      q = $urandom_range(0, 99);
      if (q < 5) begin
        push_word(FUNC_NEW_FRAME, LL_CODE_W'($urandom), EXTRA_W'($urandom),
                  ML_CODE_W'($urandom), EXTRA_W'($urandom), OF_CODE_W'($urandom),
                  OF_EXTRA_W'($urandom), c == 625);
      end else begin
        q = $urandom_range(0, 9);
        if (q == 0) llc = 0;
        else if (q == 1) llc = LL_CODE_W'($urandom_range(36, 63));
        else if (q < 8) llc = LL_CODE_W'($urandom_range(0, 35));
        else llc = LL_CODE_W'($urandom_range(0, 63));
        q = $urandom_range(0, 9);
        mlc = (q < 8) ? ML_CODE_W'($urandom_range(0, 52)) :
                        ML_CODE_W'($urandom_range(0, 63));
        q = $urandom_range(0, 9);
        if (q < 5) ofc = OF_CODE_W'($urandom_range(0, 1));
        else if (q < 7) ofc = OF_CODE_W'($urandom_range(2, 4));
        else ofc = OF_CODE_W'($urandom_range(2, 31));
        ofe = $urandom_range(0, 1) ? OF_EXTRA_W'($urandom) :
                                     OF_EXTRA_W'($urandom_range(0, 1));
        push_word(FUNC_DECODE, llc, EXTRA_W'($urandom), mlc, EXTRA_W'($urandom),
                  ofc, ofe, c == 0 || c == 625);
      end
    end
    words_total = sequence_words.size();

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // all words in and all results out, then a few cycles for strays
    while (!(words_taken == words_total && decoded_backlog.size() == 0)) begin
      @(negedge clk);
    end
    repeat (8) @(negedge clk);
    if (fault_count == 0 && decoded_backlog.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Input driver: new word at the falling edge once the last one was taken, its gap is over and any drain is done
  always @(negedge clk) begin
    seq_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      if (idle_left > 0) begin
        in_valid <= 1'b0;
        idle_left--;
      end else if (sequence_words.size() == 0 ||
                   (sequence_words[0].drain_first && decoded_backlog.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        w = sequence_words.pop_front();
        func <= w.func;
        ll_code <= w.ll_code;
        ll_extra <= w.ll_extra;
        ml_code <= w.ml_code;
        ml_extra <= w.ml_extra;
        of_code <= w.of_code;
        of_extra <= w.of_extra;
        in_valid <= 1'b1;
        idle_left = w.gap;
      end
    end
  end

  // Output stall: mostly open, short bursts, rare long ones, calm stretches
  always @(negedge clk) begin
    int unsigned roll;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (ostall_left > 0) begin
      out_stall <= 1'b1;
      ostall_left--;
    end else if (ocalm_left > 0) begin
      out_stall <= 1'b0;
      ocalm_left--;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        ocalm_left = $urandom_range(50, 200);
        out_stall <= 1'b0;
      end else if (roll < 70) begin
        out_stall <= 1'b0;
      end else if (roll < 96) begin
        ostall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        ostall_left = $urandom_range(10, 60);
        out_stall <= 1'b1;
      end
    end
  end

  // Monitor: check the output word first, then predict the input word, so
  // a word taken and one delivered on the same edge stay in order
  always @(posedge clk) begin
    seq_word_t   w;
    seq_values_t want;
    seq_values_t got;
    word_taken = rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      got = '{lit_len, copy_len, match_offset, bad_repeat};
      if (decoded_backlog.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("unexpected word: lit %0d match %0d offset %0d bad %0b",
                   got.lit_len, got.copy_len, got.match_offset, got.bad_repeat);
        end
      end else begin
        want = decoded_backlog.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("mismatch: lit %0d/%0d match %0d/%0d offset %0d/%0d bad %0b/%0b",
                     want.lit_len, got.lit_len, want.copy_len, got.copy_len,
                     want.match_offset, got.match_offset, want.bad_repeat,
                     got.bad_repeat);
          end
        end
      end
    end
    if (word_taken) begin
      w.func = func_e'(func);
      w.ll_code = ll_code;
      w.ll_extra = ll_extra;
      w.ml_code = ml_code;
      w.ml_extra = ml_extra;
      w.of_code = of_code;
      w.of_extra = of_extra;
      w.gap = 0;
      w.drain_first = 1'b0;
      if (decode_sequence(w, want)) decoded_backlog.insert(decoded_backlog.size(), want);
      words_taken++;
    end
  end

  // hang guard
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

/* zstd_sequence_value_decode.f */
rtl/zsvd_pkg.sv
rtl/zsvd_len_dec.sv
rtl/zstd_sequence_value_decode.sv
tb/tb_zstd_sequence_value_decode.sv
